FILE: design/tlf_pkg.sv
// Shared constants, types, microcode table and dispatch helpers of the line formatter.
package tlf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int CNT_W         = 4 * NUMBER_DIGITS;
  localparam int DIG_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  // mode register bits
  localparam int MODE_NUM_NB   = 0;
  localparam int MODE_NUM_ALL  = 1;
  localparam int MODE_ENDS     = 2;
  localparam int MODE_TABS     = 3;
  localparam int MODE_NONPRINT = 4;
  localparam int MODE_SQUEEZE  = 5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CTL_LIM = 8'h20;

  typedef logic [3:0] uaddr_t;

  // microprogram addresses
  localparam uaddr_t U_HDOL  = 4'd0;
  localparam uaddr_t U_HNL   = 4'd1;
  localparam uaddr_t U_DIG   = 4'd2;
  localparam uaddr_t U_NTAB  = 4'd3;
  localparam uaddr_t U_DOL   = 4'd4;
  localparam uaddr_t U_TABI0 = 4'd5;
  localparam uaddr_t U_TABI1 = 4'd6;
  localparam uaddr_t U_CTL0  = 4'd7;
  localparam uaddr_t U_CTL1  = 4'd8;
  localparam uaddr_t U_DEL0  = 4'd9;
  localparam uaddr_t U_DEL1  = 4'd10;
  localparam uaddr_t U_META0 = 4'd11;
  localparam uaddr_t U_META1 = 4'd12;
  localparam uaddr_t U_MRAW  = 4'd13;
  localparam uaddr_t U_RAW   = 4'd14;

  typedef enum logic [2:0] {
    ES_LIT,
    ES_DIGIT,
    ES_CTL,
    ES_LOW7,
    ES_RAW
  } esrc_e;

  typedef enum logic [2:0] {
    NX_SEQ,
    NX_LOOP,
    NX_DISP,
    NX_BRMC,
    NX_END
  } nxt_e;

  typedef enum logic [2:0] {
    K_RAW,
    K_TABI,
    K_CTL,
    K_DEL,
    K_MCTL,
    K_MRAW
  } kind_e;

  typedef struct packed {
    esrc_e      esrc;
    logic [7:0] lit;
    nxt_e       nxt;
    uaddr_t     tgt;
  } ucw_t;

  // segments still to run for the current byte
  typedef struct packed {
    logic hold;
    logic hold_dol;
    logic num;
    logic dol;
  } pend_t;

  function automatic ucw_t ucode(uaddr_t a);
    ucw_t w;
    unique case (a)
      U_HDOL:  w = '{ES_LIT,   CH_DOLLAR, NX_SEQ,  U_HDOL};
      U_HNL:   w = '{ES_LIT,   CH_NL,     NX_DISP, U_HDOL};
      U_DIG:   w = '{ES_DIGIT, CH_SPACE,  NX_LOOP, U_HDOL};
      U_NTAB:  w = '{ES_LIT,   CH_TAB,    NX_DISP, U_HDOL};
      U_DOL:   w = '{ES_LIT,   CH_DOLLAR, NX_DISP, U_HDOL};
      U_TABI0: w = '{ES_LIT,   CH_CARET,  NX_SEQ,  U_HDOL};
      U_TABI1: w = '{ES_LIT,   CH_I,      NX_END,  U_HDOL};
      U_CTL0:  w = '{ES_LIT,   CH_CARET,  NX_SEQ,  U_HDOL};
      U_CTL1:  w = '{ES_CTL,   CH_CARET,  NX_END,  U_HDOL};
      U_DEL0:  w = '{ES_LIT,   CH_CARET,  NX_SEQ,  U_HDOL};
      U_DEL1:  w = '{ES_LIT,   CH_QMARK,  NX_END,  U_HDOL};
      U_META0: w = '{ES_LIT,   CH_M,      NX_SEQ,  U_HDOL};
      U_META1: w = '{ES_LIT,   CH_DASH,   NX_BRMC, U_CTL0};
      U_MRAW:  w = '{ES_LOW7,  CH_SPACE,  NX_END,  U_HDOL};
      U_RAW:   w = '{ES_RAW,   CH_SPACE,  NX_END,  U_HDOL};
      default: w = '{ES_RAW,   CH_SPACE,  NX_END,  U_HDOL};
    endcase
    return w;
  endfunction

  function automatic uaddr_t dispatch(pend_t p, kind_e k);
    uaddr_t a;
    priority if (p.hold) begin
      a = p.hold_dol ? U_HDOL : U_HNL;
    end else if (p.num) begin
      a = U_DIG;
    end else if (p.dol) begin
      a = U_DOL;
    end else begin
      unique case (k)
        K_TABI:         a = U_TABI0;
        K_CTL:          a = U_CTL0;
        K_DEL:          a = U_DEL0;
        K_MCTL, K_MRAW: a = U_META0;
        default:        a = U_RAW;
      endcase
    end
    return a;
  endfunction

  // drop the segment that dispatch just picked
  function automatic pend_t take(pend_t p);
    pend_t r;
    r = p;
    priority if (p.hold) begin
      r.hold = 1'b0;
    end else if (p.num) begin
      r.num = 1'b0;
    end else begin
      r.dol = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: design/text_stream_line_formatter_unit.sv
// Top level of the line formatter: input decode, microcoded output sequencer, output register.
//
// Usage: raw text bytes enter on the in_ channel (valid/ready) together with a
// start_of_file flag that clears line count and line flags before the byte is
// handled. Formatted bytes leave on the out_ channel, one per transfer, with
// last_of_run marking the final byte caused by an input byte. A newline held
// back by squeezing causes no output at all and the block is ready again at once.
// The mode register is written through cfg_we_i / cfg_wdata_i while idle; the user
// must keep to this, the block itself does not enforce it. An input byte causes
// one output byte if plain, up to 13 with a line number, held newline and an
// M-^X escape; the sequencer emits one byte per microcode step while the receiver
// keeps up. The input transfer loads the sequencer, whose first step fills the
// output register. The next input byte is taken while the last output byte still
// waits in the output register. A receiver stall freezes the sequencer; the
// waiting byte holds. Reset clears the mode register, the line state and the
// sequencer; no clearing pass is needed.
module text_stream_line_formatter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_of_file_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import tlf_pkg::*;

  logic [5:0]       mode_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             inside_q, inside_d;
  logic             als_q, als_d;
  logic             prev_q, prev_d;
  logic             held_q, held_d;

  logic             busy_q;
  uaddr_t           upc_q, upc_d;
  pend_t            pend_q, pend_d, pend_start;
  kind_e            kind_q, kind_d;
  logic [7:0]       c_q;
  logic [DIG_W-1:0] idx_q;
  logic             lead_q;

  logic             ov_q;
  logic [7:0]       ob_q, ob_d;
  logic             ol_q;

  logic             accept, adv, swallow;
  ucw_t             w;
  logic [3:0]       dig, dig_sat;
  logic             blank;

  assign in_ready_o    = ~busy_q;
  assign accept        = in_valid_i & ~busy_q;
  assign adv           = busy_q & (~ov_q | out_ready_i);
  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign last_of_run_o = ol_q;

  // input decode and line state update
  always_comb begin
    logic [7:0]       c;
    logic [6:0]       h;
    logic             nl, sq, num, all9, carry;
    logic [CNT_W-1:0] cnt_b, inc;
    logic             inside_b, als_b, prev_b, held_b, hold_emit;
    c        = in_byte_i;
    h        = in_byte_i[6:0];
    nl       = (c == CH_NL);
    sq       = mode_q[MODE_SQUEEZE];
    cnt_b    = start_of_file_i ? '0 : cnt_q;
    inside_b = start_of_file_i ? 1'b0 : inside_q;
    als_b    = start_of_file_i ? 1'b1 : als_q;
    prev_b   = start_of_file_i ? 1'b0 : prev_q;
    held_b   = start_of_file_i ? 1'b0 : held_q;

    swallow   = sq & nl & prev_b;
    hold_emit = sq & ~nl & held_b;
    held_d    = swallow | (held_b & ~hold_emit);
    prev_d    = sq ? nl : prev_b;

    inside_d = inside_b;
    als_d    = als_b;
    num      = 1'b0;
    if (!swallow) begin
      if (mode_q[MODE_NUM_NB]) begin
        if (nl) begin
          inside_d = 1'b0;
        end else if (!inside_b) begin
          inside_d = 1'b1;
          num      = 1'b1;
        end
      end else if (mode_q[MODE_NUM_ALL]) begin
        num   = als_b;
        als_d = nl;
      end
    end

    // saturating BCD increment
    all9 = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (cnt_b[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    inc   = cnt_b;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (inc[4*i +: 4] >= 4'd9) begin
          inc[4*i +: 4] = 4'd0;
        end else begin
          inc[4*i +: 4] = inc[4*i +: 4] + 4'd1;
          carry         = 1'b0;
        end
      end
    end
    if (all9) inc = cnt_b;
    cnt_d = num ? inc : cnt_b;

    priority if (mode_q[MODE_TABS] && c == CH_TAB) begin
      kind_d = K_TABI;
    end else if (mode_q[MODE_NONPRINT] && c < CH_CTL_LIM && c != CH_TAB && c != CH_NL) begin
      kind_d = K_CTL;
    end else if (mode_q[MODE_NONPRINT] && c == CH_DEL) begin
      kind_d = K_DEL;
    end else if (mode_q[MODE_NONPRINT] && c[7]) begin
      if (h < CH_CTL_LIM[6:0] && h != CH_TAB[6:0] && h != CH_NL[6:0]) begin
        kind_d = K_MCTL;
      end else begin
        kind_d = K_MRAW;
      end
    end else begin
      kind_d = K_RAW;
    end

    pend_start.hold     = hold_emit;
    pend_start.hold_dol = mode_q[MODE_ENDS];
    pend_start.num      = num;
    pend_start.dol      = mode_q[MODE_ENDS] & nl;
  end

  // microcode step: output byte and next address
  always_comb begin
    w       = ucode(upc_q);
    dig     = cnt_q[{idx_q, 2'b00} +: 4];
    dig_sat = (dig > 4'd9) ? 4'd9 : dig;
    blank   = lead_q & (dig == 4'd0) & (idx_q != '0);
    unique case (w.esrc)
      ES_LIT:   ob_d = w.lit;
      ES_DIGIT: ob_d = blank ? CH_SPACE : CH_ZERO + {4'b0000, dig_sat};
      ES_CTL:   ob_d = {3'b010, c_q[4:0]};
      ES_LOW7:  ob_d = {1'b0, c_q[6:0]};
      default:  ob_d = c_q;
    endcase
    pend_d = pend_q;
    unique case (w.nxt)
      NX_SEQ:  upc_d = upc_q + 4'd1;
      NX_LOOP: upc_d = (idx_q != '0) ? upc_q : upc_q + 4'd1;
      NX_DISP: begin
        upc_d  = dispatch(pend_q, kind_q);
        pend_d = take(pend_q);
      end
      NX_BRMC: upc_d = (kind_q == K_MCTL) ? w.tgt : upc_q + 4'd1;
      default: upc_d = upc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      cnt_q    <= '0;
      inside_q <= 1'b0;
      als_q    <= 1'b1;
      prev_q   <= 1'b0;
      held_q   <= 1'b0;
      busy_q   <= 1'b0;
      upc_q    <= U_RAW;
      pend_q   <= '0;
      kind_q   <= K_RAW;
      idx_q    <= '0;
      lead_q   <= 1'b0;
      ov_q     <= 1'b0;
      ol_q     <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      // load on a step, drop on a transfer
      if (adv) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (accept) begin
        cnt_q    <= cnt_d;
        inside_q <= inside_d;
        als_q    <= als_d;
        prev_q   <= prev_d;
        held_q   <= held_d;
        if (!swallow) begin
          busy_q <= 1'b1;
          upc_q  <= dispatch(pend_start, kind_d);
          pend_q <= take(pend_start);
          kind_q <= kind_d;
          idx_q  <= DIG_W'(NUMBER_DIGITS - 1);
          lead_q <= 1'b1;
        end
      end else if (adv) begin
        ol_q  <= (w.nxt == NX_END);
        upc_q <= upc_d;
        pend_q <= pend_d;
        if (w.nxt == NX_END) busy_q <= 1'b0;
        if (w.esrc == ES_DIGIT) begin
          lead_q <= blank;
          if (idx_q != '0) idx_q <= idx_q - DIG_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) c_q <= in_byte_i;
    if (adv) ob_q <= ob_d;
  end

endmodule

FILE: design/tlf_checker.sv
// Port-level checker for the line formatter, bound to the top level.
module tlf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);

  // hold a stalled output byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_of_run_o))
    else $error("stalled output byte changed");

  // a waiting byte that is not the last one means the run is still going
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o)
    else $error("input taken while a run is unfinished");

  // the run ends exactly when its last byte enters the output register
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && last_of_run_o)
    else $error("ready returned without a final byte");

endmodule

bind text_stream_line_formatter_unit tlf_checker u_tlf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);

FILE: bench/text_stream_line_formatter_unit_test.sv
// Self-checking bench for the line formatter: random text bytes under many modes, scored per output byte.
`timescale 1ns / 1ps

module text_stream_line_formatter_unit_test;
  import tlf_pkg::*;

  localparam logic [7:0] CTL_SHOW_OFS  = 8'h40;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         MAX_REPORTS   = 100;

  // Tracks the formatter's line state and mode, and holds the bytes still owed.
  class line_format_tracker;
    logic [5:0]         mode;
    logic [CNT_W-1:0]   count_bcd;
    bit                 in_nonblank;
    bit                 at_start;
    bit                 prev_nl;
    bit                 nl_held;
    logic [7:0]         run[$];
    logic [8:0]         due_bytes[$];
    int                 mismatches;

    function new();
      mode = '0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      count_bcd   = '0;
      in_nonblank = 1'b0;
      at_start    = 1'b1;
      prev_nl     = 1'b0;
      nl_held     = 1'b0;
    endfunction

    function void bump_number();
      bit         all_nine;
      bit         leading;
      logic [3:0] d;
      all_nine = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++)
        if (count_bcd[4*i +: 4] != 4'd9) all_nine = 1'b0;
      // saturate at all nines, else ripple the BCD carry
      if (!all_nine) begin
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
          if (count_bcd[4*i +: 4] >= 4'd9) begin
            count_bcd[4*i +: 4] = 4'd0;
          end else begin
            count_bcd[4*i +: 4] = count_bcd[4*i +: 4] + 4'd1;
            break;
          end
        end
      end
      leading = 1'b1;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
        d = count_bcd[4*i +: 4];
        if (d != 4'd0 || i == 0) leading = 1'b0;
        run.push_back(leading ? CH_SPACE : CH_ZERO + ((d > 4'd9) ? 8'd9 : {4'd0, d}));
      end
      run.push_back(CH_TAB);
    endfunction

    function void render(logic [7:0] c);
      bit         done;
      logic [7:0] h;
      done = 1'b0;
      if (mode[MODE_NUM_NB]) begin
        if (c == CH_NL) begin
          in_nonblank = 1'b0;
        end else if (!in_nonblank) begin
          in_nonblank = 1'b1;
          bump_number();
        end
      end else if (mode[MODE_NUM_ALL]) begin
        if (at_start) begin
          bump_number();
          at_start = 1'b0;
        end
        if (c == CH_NL) at_start = 1'b1;
      end
      if (mode[MODE_ENDS] && c == CH_NL) run.push_back(CH_DOLLAR);
      if (mode[MODE_TABS] && c == CH_TAB) begin
        run.push_back(CH_CARET);
        run.push_back(CH_I);
        done = 1'b1;
      end
      if (mode[MODE_NONPRINT] && !done) begin
        if (c < CH_CTL_LIM && c != CH_TAB && c != CH_NL) begin
          run.push_back(CH_CARET);
          run.push_back(c + CTL_SHOW_OFS);
          done = 1'b1;
        end else if (c == CH_DEL) begin
          run.push_back(CH_CARET);
          run.push_back(CH_QMARK);
          done = 1'b1;
        end else if (c[7]) begin
          h = {1'b0, c[6:0]};
          run.push_back(CH_M);
          run.push_back(CH_DASH);
          // the low half of 255 goes out raw as DEL, tab and newline raw too
          if (h < CH_CTL_LIM && h != CH_TAB && h != CH_NL) begin
            run.push_back(CH_CARET);
            run.push_back(h + CTL_SHOW_OFS);
          end else begin
            run.push_back(h);
          end
          done = 1'b1;
        end
      end
      if (!done) run.push_back(c);
    endfunction

    function void format_input(logic [7:0] c, logic sof);
      run.delete();
      if (sof) clear_line();
      if (mode[MODE_SQUEEZE]) begin
        if (c == CH_NL) begin
          // hold a repeated newline back, nothing goes out
          if (prev_nl) begin
            nl_held = 1'b1;
            return;
          end
          prev_nl = 1'b1;
        end else begin
          if (nl_held) begin
            if (mode[MODE_ENDS]) run.push_back(CH_DOLLAR);
            run.push_back(CH_NL);
            nl_held = 1'b0;
          end
          prev_nl = 1'b0;
        end
      end
      render(c);
      foreach (run[k])
        due_bytes.push_back({(k == run.size() - 1) ? 1'b1 : 1'b0, run[k]});
    endfunction

    function void check_result(logic [7:0] b, logic last);
      logic [8:0] want;
      if (due_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: output byte %02h last %0b with none expected", $time, b, last);
        return;
      end
      want = due_bytes.pop_front();
      if (want[7:0] !== b) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: out_byte expected %02h actual %02h", $time, want[7:0], b);
      end
      if (want[8] !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: last_of_run expected %0b actual %0b", $time, want[8], last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       start_of_file_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  line_format_tracker tracker = new();

  text_stream_line_formatter_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .start_of_file_i(start_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Note input transfers before scoring output ones in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.format_input(in_byte_i, start_of_file_i);
      if (out_valid_o && out_ready_i) tracker.check_result(out_byte_o, last_of_run_o);
    end
  end

  // Receiver: switch between stall styles every so often.
  initial begin
    int style;
    int span;
    int cyc;
    out_ready_i = 1'b0;
    style = 0;
    span  = 0;
    cyc   = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(20, 120);
      end
      span--;
      cyc++;
      case (style)
        0: begin
          out_ready_i = 1'b1;
        end
        1: begin
          out_ready_i = ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_ready_i = ($urandom_range(0, 2) == 0);
        end
        default: begin
          out_ready_i = ((cyc % 5) < 2);
        end
      endcase
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Present one byte and hold it until the transfer; valid stays high afterwards.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    in_byte_i       = b;
    start_of_file_i = sof;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed byte, then let a held newline settle.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (tracker.due_bytes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_mode(input logic [5:0] m);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = m;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    tracker.mode = m;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return 8'($urandom_range(8'h21, 8'h7E));
    if (sel < 45) return CH_SPACE;
    if (sel < 65) return CH_NL;
    if (sel < 73) return CH_TAB;
    if (sel < 81) return 8'($urandom_range(0, 31));
    if (sel < 85) return CH_DEL;
    if (sel < 94) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_text_phase(input logic [5:0] m, input int count, input bit pause_mid);
    int burst;
    load_mode(m);
    burst = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      send_byte(pick_text_byte(), (i == 0) || ($urandom_range(0, 39) == 0));
      if (pause_mid && i == count / 2) wait_drained();
      burst--;
      if (burst == 0) begin
        idle_sender($urandom_range(1, 6));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    in_byte_i       = '0;
    start_of_file_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // plain pass-through, tab raw
    load_mode(6'h00);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_TAB, 1'b0);

    // every mode bit: held newlines, meta forms of 255, 137, 138, held newline dropped at file start
    load_mode(6'h3F);
    send_byte(8'h61, 1'b1);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h89, 1'b0);
    send_byte(8'h8A, 1'b0);
    send_byte(CH_DEL, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h78, 1'b1);

    // both numbering bits with nonprinting, tab stays raw without the tab bit
    load_mode(6'h13);
    send_byte(CH_TAB, 1'b1);
    send_byte(CH_NL, 1'b0);

    // hold a newline, turn squeeze off, then back on with ends shown
    load_mode(6'h20);
    send_byte(CH_NL, 1'b1);
    send_byte(CH_NL, 1'b0);
    load_mode(6'h00);
    send_byte(8'h7A, 1'b0);
    load_mode(6'h24);
    send_byte(8'h79, 1'b0);

    run_text_phase(6'h3F, 30, 1'b0);
    run_text_phase(6'h00, 30, 1'b1);
    run_text_phase(6'h21, 30, 1'b0);
    run_text_phase(6'h1E, 30, 1'b0);
    run_text_phase(6'($urandom_range(0, 63)), 30, 1'b1);
    run_text_phase(6'($urandom_range(0, 63)), 30, 1'b0);

    wait_drained();
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
